/* hw/rtl/i2cm_pkg.sv */
// package for the i2c master register access unit
// holds the request, phase and result types, function codes and fixed constants
// no dependencies
package i2cm_pkg;

  // function codes on the request port
  localparam logic [1:0] FuncTick  = 2'd0;
  localparam logic [1:0] FuncWrite = 2'd1;
  localparam logic [1:0] FuncRead  = 2'd2;

  // fixed sizes and defaults
  localparam logic [4:0]  MaxBurst     = 5'd16;
  localparam logic [3:0]  ByteBits     = 4'd8;
  localparam logic [15:0] TimeoutReset = 16'd1000;
  localparam logic [15:0] StretchMax   = 16'hFFFF;

  // request class decided by the front end
  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_WRITE,
    KIND_READ,
    KIND_NONE
  } kind_e;

  // classified request as held in the queue
  typedef struct packed {
    kind_e      kind;
    logic [6:0] slv_addr;
    logic [7:0] reg_ptr;
    logic [7:0] write_data;
    logic [4:0] read_count;
    logic       scl_in;
    logic       sda_in;
  } item_t;

  // sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE,
    PH_START_SDA,
    PH_START_SCL,
    PH_RESTART,
    ST_ADDR,
    ST_REG,
    ST_DATA,
    ST_STOP,
    ST_RESTART,
    ST_RADDR,
    ST_RBYTE,
    ST_RSTORE,
    PH_WBIT,
    PH_WCLKH,
    PH_WCLKL,
    PH_WGAP,
    PH_WNEXT,
    PH_AWAIT,
    PH_RBIT,
    PH_RWAIT,
    PH_RNEXT,
    PH_MCLKH,
    PH_MCLKL,
    PH_MGAP,
    PH_STOP1,
    PH_STOP2,
    PH_STOP3
  } phase_e;

  // result status travelling out of the back end
  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       busy_res;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
    logic       timeout_error;
  } result_t;

endpackage

/* hw/rtl/i2c_master_register_access_unit.sv */
// top level of the i2c master register access unit
// depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_back
//
// An i2c master that runs single register writes and burst register reads
// (one to sixteen bytes), one pin action per request: a command request
// starts a transaction, each tick request then moves the sequencer one step
// and every request yields exactly one result with the line drives, busy,
// any received byte and the sticky timeout flag. One request is taken per
// clock while the queue is not full; the front end classifies it into a two
// entry queue and the back end sequencer executes one queued request per
// clock while the output is not stalled, so each request passes a queue
// entry and then the output register. The timeout limit (reset 1000 ticks)
// is written over the configuration port, which is always ready.
module i2c_master_register_access_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [6:0]  slv_addr_i,
  input  logic [7:0]  reg_ptr_i,
  input  logic [7:0]  write_data_i,
  input  logic [4:0]  read_count_i,
  input  logic        scl_in_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_drive_o,
  output logic        sda_drive_o,
  output logic        busy_res_o,
  output logic [7:0]  read_data_o,
  output logic        read_valid_o,
  output logic        read_last_o,
  output logic        timeout_error_o
);
  import i2cm_pkg::*;

  logic [15:0] timeout_q;
  logic        q_full;
  logic        push;
  item_t       push_item;
  logic        pop;
  logic        q_valid;
  item_t       q_item;
  result_t     result;

  // timeout limit register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_data_i;
    end
  end

  i2cm_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .slv_addr_i    (slv_addr_i),
    .reg_ptr_i     (reg_ptr_i),
    .write_data_i  (write_data_i),
    .read_count_i  (read_count_i),
    .scl_in_i      (scl_in_i),
    .sda_in_i      (sda_in_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  i2cm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (q_item)
  );

  i2cm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .timeout_limit_i (timeout_q),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_o        (result)
  );

  assign scl_drive_o     = result.scl_drive;
  assign sda_drive_o     = result.sda_drive;
  assign busy_res_o      = result.busy_res;
  assign read_data_o     = result.read_data;
  assign read_valid_o    = result.read_valid;
  assign read_last_o     = result.read_last;
  assign timeout_error_o = result.timeout_error;

endmodule

/* hw/rtl/i2cm_front.sv */
// front end: takes requests, decodes the function and clamps the burst length
// depends on i2cm_pkg
module i2cm_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  logic [6:0]        slv_addr_i,
  input  logic [7:0]        reg_ptr_i,
  input  logic [7:0]        write_data_i,
  input  logic [4:0]        read_count_i,
  input  logic              scl_in_i,
  input  logic              sda_in_i,
  input  logic              q_full_i,
  output logic              push_o,
  output i2cm_pkg::item_t   push_item_o
);
  import i2cm_pkg::*;

  kind_e      kind;
  logic [4:0] count;

  // function decode, code three decodes to KIND_NONE and is queued as a no-op
  always_comb begin
    case (func_i)
      FuncTick:  kind = KIND_TICK;
      FuncWrite: kind = KIND_WRITE;
      FuncRead:  kind = KIND_READ;
      default:   kind = KIND_NONE;
    endcase
  end

  // zero length reads one byte, long bursts clamp to the maximum
  always_comb begin
    if (read_count_i == 5'd0) begin
      count = 5'd1;
    end else if (read_count_i > MaxBurst) begin
      count = MaxBurst;
    end else begin
      count = read_count_i;
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  assign push_item_o.kind        = kind;
  assign push_item_o.slv_addr    = slv_addr_i;
  assign push_item_o.reg_ptr     = reg_ptr_i;
  assign push_item_o.write_data  = write_data_i;
  assign push_item_o.read_count  = count;
  assign push_item_o.scl_in      = scl_in_i;
  assign push_item_o.sda_in      = sda_in_i;

endmodule

/* hw/rtl/i2cm_queue.sv */
// two entry request queue between the front and back ends
// depends on i2cm_pkg
module i2cm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  i2cm_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output i2cm_pkg::item_t pop_item_o
);
  import i2cm_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_item_o = mem_q[rd_ptr_q];

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* hw/rtl/i2cm_back.sv */
// back end: i2c sequencer, one pin action per request, with output register
// depends on i2cm_pkg
module i2cm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [15:0]       timeout_limit_i,
  input  logic              q_valid_i,
  input  i2cm_pkg::item_t   q_item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output i2cm_pkg::result_t result_o
);
  import i2cm_pkg::*;

  phase_e      phase_q, phase_d;
  phase_e      after_q, after_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  shift_out_q, shift_out_d;
  logic [7:0]  shift_in_q, shift_in_d;
  logic [4:0]  bytes_done_q, bytes_done_d;
  logic [4:0]  bytes_wanted_q, bytes_wanted_d;
  logic [15:0] stretch_q, stretch_d;
  logic        err_q, err_d;
  logic [6:0]  slave_q, slave_d;
  logic [7:0]  reg_addr_q, reg_addr_d;
  logic [7:0]  data_q, data_d;
  logic        is_read_q, is_read_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        out_valid_q, out_valid_d;
  result_t     result_q, result_d;

  // clock stretch evaluation
  logic [15:0] st_inc1;
  logic [15:0] st_mid;
  logic [15:0] st_inc2;
  logic        st_wait;
  logic        st_err;
  // shared helpers
  logic [3:0]  bit_cnt_inc;
  logic [7:0]  shift_out_sh;
  logic [7:0]  shift_in_sh;
  logic [4:0]  bytes_done_inc;
  logic        last_next;
  logic        last_cur;

  assign pop_o       = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // stretch wait: a low clock waits until the limit, then flags and moves on
  always_comb begin
    st_inc1 = (stretch_q == StretchMax) ? stretch_q : stretch_q + 16'd1;
    st_mid  = q_item_i.scl_in ? stretch_q : st_inc1;
    st_inc2 = (st_mid == StretchMax) ? st_mid : st_mid + 16'd1;
    st_wait = ~q_item_i.scl_in & (stretch_q < timeout_limit_i);
    st_err  = (st_mid >= timeout_limit_i);
  end

  always_comb begin
    bit_cnt_inc    = bit_cnt_q + 4'd1;
    shift_out_sh   = {shift_out_q[6:0], 1'b0};
    shift_in_sh    = {shift_in_q[6:0], 1'b0};
    bytes_done_inc = bytes_done_q + 5'd1;
    last_cur       = (({1'b0, bytes_done_q} + 6'd1) >= {1'b0, bytes_wanted_q});
    last_next      = (({1'b0, bytes_done_inc} + 6'd1) >= {1'b0, bytes_wanted_q});
  end

  // sequencer step
  always_comb begin
    phase_d        = phase_q;
    after_d        = after_q;
    bit_cnt_d      = bit_cnt_q;
    shift_out_d    = shift_out_q;
    shift_in_d     = shift_in_q;
    bytes_done_d   = bytes_done_q;
    bytes_wanted_d = bytes_wanted_q;
    stretch_d      = stretch_q;
    err_d          = err_q;
    slave_d        = slave_q;
    reg_addr_d     = reg_addr_q;
    data_d         = data_q;
    is_read_d      = is_read_q;
    scl_d          = scl_q;
    sda_d          = sda_q;
    result_d       = result_q;

    result_d.read_data  = 8'd0;
    result_d.read_valid = 1'b0;
    result_d.read_last  = 1'b0;

    case (q_item_i.kind)
      KIND_WRITE, KIND_READ: begin
        // a command starts a transaction only when idle
        if (phase_q == PH_IDLE) begin
          slave_d        = q_item_i.slv_addr;
          reg_addr_d     = q_item_i.reg_ptr;
          data_d         = q_item_i.write_data;
          is_read_d      = (q_item_i.kind == KIND_READ);
          bytes_wanted_d = q_item_i.read_count;
          bytes_done_d   = 5'd0;
          shift_in_d     = 8'd0;
          scl_d          = 1'b1;
          sda_d          = 1'b1;
          phase_d        = PH_START_SDA;
          after_d        = ST_ADDR;
        end
      end
      KIND_TICK: begin
        case (phase_q)
          PH_START_SDA: begin
            sda_d   = 1'b0;
            phase_d = PH_START_SCL;
          end
          PH_START_SCL: begin
            scl_d   = 1'b0;
            phase_d = after_q;
          end
          PH_RESTART: begin
            scl_d   = 1'b1;
            sda_d   = 1'b1;
            phase_d = PH_START_SDA;
          end
          ST_ADDR: begin
            shift_out_d = {slave_q, 1'b0};
            bit_cnt_d   = 4'd0;
            phase_d     = PH_WBIT;
            after_d     = ST_REG;
          end
          ST_REG: begin
            shift_out_d = reg_addr_q;
            bit_cnt_d   = 4'd0;
            phase_d     = PH_WBIT;
            after_d     = is_read_q ? ST_RESTART : ST_DATA;
          end
          ST_DATA: begin
            shift_out_d = data_q;
            bit_cnt_d   = 4'd0;
            phase_d     = PH_WBIT;
            after_d     = ST_STOP;
          end
          ST_STOP: begin
            phase_d = PH_STOP1;
            after_d = PH_IDLE;
          end
          ST_RESTART: begin
            phase_d = PH_RESTART;
            after_d = ST_RADDR;
          end
          ST_RADDR: begin
            shift_out_d = {slave_q, 1'b1};
            bit_cnt_d   = 4'd0;
            phase_d     = PH_WBIT;
            after_d     = ST_RBYTE;
          end
          ST_RBYTE: begin
            // master ack bit parked in the top of the shift register
            shift_out_d = last_cur ? 8'h80 : 8'h00;
            bit_cnt_d   = 4'd0;
            sda_d       = 1'b1;
            phase_d     = PH_RBIT;
            after_d     = ST_RSTORE;
          end
          ST_RSTORE: begin
            result_d.read_data  = shift_in_q;
            result_d.read_valid = 1'b1;
            bytes_done_d        = bytes_done_inc;
            if (bytes_done_inc >= bytes_wanted_q) begin
              result_d.read_last = 1'b1;
              phase_d            = PH_STOP1;
              after_d            = PH_IDLE;
            end else begin
              shift_in_d  = 8'd0;
              shift_out_d = last_next ? 8'h80 : 8'h00;
              bit_cnt_d   = 4'd0;
              sda_d       = 1'b1;
              phase_d     = PH_RBIT;
            end
          end
          PH_WBIT: begin
            sda_d   = shift_out_q[7];
            phase_d = PH_WCLKH;
          end
          PH_WCLKH: begin
            scl_d   = 1'b1;
            phase_d = PH_WCLKL;
          end
          PH_WCLKL: begin
            scl_d   = 1'b0;
            phase_d = PH_WGAP;
          end
          PH_WGAP: begin
            phase_d = PH_WNEXT;
          end
          PH_WNEXT: begin
            shift_out_d = shift_out_sh;
            bit_cnt_d   = bit_cnt_inc;
            if (bit_cnt_inc >= ByteBits) begin
              scl_d     = 1'b1;
              stretch_d = 16'd0;
              phase_d   = PH_AWAIT;
            end else begin
              sda_d   = shift_out_sh[7];
              phase_d = PH_WCLKH;
            end
          end
          PH_AWAIT: begin
            // slave ack clocked but not used
            if (st_wait) begin
              stretch_d = st_inc1;
            end else begin
              stretch_d = st_inc2;
              if (st_err) begin
                err_d = 1'b1;
              end
              scl_d   = 1'b0;
              phase_d = after_q;
            end
          end
          PH_RBIT: begin
            shift_in_d = shift_in_sh;
            scl_d      = 1'b1;
            stretch_d  = 16'd0;
            phase_d    = PH_RWAIT;
          end
          PH_RWAIT: begin
            if (st_wait) begin
              stretch_d = st_inc1;
            end else begin
              stretch_d = st_inc2;
              if (st_err) begin
                err_d = 1'b1;
              end
              shift_in_d = {shift_in_q[7:1], shift_in_q[0] | q_item_i.sda_in};
              scl_d      = 1'b0;
              phase_d    = PH_RNEXT;
            end
          end
          PH_RNEXT: begin
            bit_cnt_d = bit_cnt_inc;
            if (bit_cnt_inc >= ByteBits) begin
              sda_d   = shift_out_q[7];
              phase_d = PH_MCLKH;
            end else begin
              shift_in_d = shift_in_sh;
              scl_d      = 1'b1;
              stretch_d  = 16'd0;
              phase_d    = PH_RWAIT;
            end
          end
          PH_MCLKH: begin
            scl_d   = 1'b1;
            phase_d = PH_MCLKL;
          end
          PH_MCLKL: begin
            scl_d   = 1'b0;
            phase_d = PH_MGAP;
          end
          PH_MGAP: begin
            phase_d = after_q;
          end
          PH_STOP1: begin
            sda_d   = 1'b0;
            phase_d = PH_STOP2;
          end
          PH_STOP2: begin
            scl_d   = 1'b1;
            phase_d = PH_STOP3;
          end
          PH_STOP3: begin
            sda_d   = 1'b1;
            phase_d = PH_IDLE;
            after_d = PH_IDLE;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
      default: begin
        // unknown function code leaves everything as it is
      end
    endcase

    result_d.scl_drive     = scl_d;
    result_d.sda_drive     = sda_d;
    result_d.busy_res      = (phase_d != PH_IDLE);
    result_d.timeout_error = err_d;
  end

  // output register valid
  always_comb begin
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // sequencer state, updated only on a popped request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      after_q        <= PH_IDLE;
      bit_cnt_q      <= 4'd0;
      shift_out_q    <= 8'd0;
      shift_in_q     <= 8'd0;
      bytes_done_q   <= 5'd0;
      bytes_wanted_q <= 5'd0;
      stretch_q      <= 16'd0;
      err_q          <= 1'b0;
      slave_q        <= 7'd0;
      reg_addr_q     <= 8'd0;
      data_q         <= 8'd0;
      is_read_q      <= 1'b0;
      scl_q          <= 1'b1;
      sda_q          <= 1'b1;
    end else if (pop_o) begin
      phase_q        <= phase_d;
      after_q        <= after_d;
      bit_cnt_q      <= bit_cnt_d;
      shift_out_q    <= shift_out_d;
      shift_in_q     <= shift_in_d;
      bytes_done_q   <= bytes_done_d;
      bytes_wanted_q <= bytes_wanted_d;
      stretch_q      <= stretch_d;
      err_q          <= err_d;
      slave_q        <= slave_d;
      reg_addr_q     <= reg_addr_d;
      data_q         <= data_d;
      is_read_q      <= is_read_d;
      scl_q          <= scl_d;
      sda_q          <= sda_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= result_d;
    end
  end

endmodule
